// ----- hw/rtl/bgd_pkg.sv -----
// shared types, codes and constants for the button gesture detector
package bgd_pkg;

  localparam int unsigned NUM_BUTTONS = 5;
  localparam int unsigned BTN_IDX_W   = 3;
  localparam int unsigned CFG_W       = 24;

  // button positions in the level word, also the evaluation order
  localparam logic [BTN_IDX_W-1:0] BTN_CENTER = 3'd0;
  localparam logic [BTN_IDX_W-1:0] BTN_UP     = 3'd1;
  localparam logic [BTN_IDX_W-1:0] BTN_DOWN   = 3'd2;
  localparam logic [BTN_IDX_W-1:0] BTN_LEFT   = 3'd3;
  localparam logic [BTN_IDX_W-1:0] BTN_RIGHT  = 3'd4;

  localparam logic [CFG_W-1:0] LONG_PRESS_RESET   = 24'd800000;
  localparam logic [CFG_W-1:0] DOUBLE_CLICK_RESET = 24'd400000;

  typedef enum logic {
    CFG_LONG_PRESS   = 1'b0,
    CFG_DOUBLE_CLICK = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    EV_NONE          = 4'd0,
    EV_CENTER        = 4'd1,
    EV_CENTER_DOUBLE = 4'd2,
    EV_CENTER_LONG   = 4'd3,
    EV_UP            = 4'd4,
    EV_UP_LONG       = 4'd5,
    EV_DOWN          = 4'd6,
    EV_DOWN_LONG     = 4'd7,
    EV_LEFT          = 4'd8,
    EV_LEFT_LONG     = 4'd9,
    EV_RIGHT         = 4'd10,
    EV_RIGHT_LONG    = 4'd11
  } event_e;

  // per-button flags
  typedef struct packed {
    logic held;
    logic long_rep;
  } btn_flags_t;

  // what one button found on this poll
  typedef struct packed {
    logic long_ev;
    logic click_ev;
  } btn_ev_t;

  // event code of a plain button, centre is handled by the window logic
  function automatic event_e btn_code(input logic [BTN_IDX_W-1:0] idx, input logic is_long);
    event_e code;
    begin
      code = EV_NONE;
      unique case (idx)
        BTN_UP:    code = is_long ? EV_UP_LONG    : EV_UP;
        BTN_DOWN:  code = is_long ? EV_DOWN_LONG  : EV_DOWN;
        BTN_LEFT:  code = is_long ? EV_LEFT_LONG  : EV_LEFT;
        BTN_RIGHT: code = is_long ? EV_RIGHT_LONG : EV_RIGHT;
        default:   code = EV_NONE;
      endcase
      return code;
    end
  endfunction

endpackage

// ----- hw/rtl/bgd_button.sv -----
// press tracking, long-press and click detection for one button
module bgd_button #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                         level_i,
  input  logic [TIME_BITS-1:0]         now_i,
  input  bgd_pkg::btn_flags_t          flags_i,
  input  logic [TIME_BITS-1:0]         start_i,
  input  logic [bgd_pkg::CFG_W-1:0]    long_press_us_i,
  output bgd_pkg::btn_flags_t          flags_o,
  output logic [TIME_BITS-1:0]         start_o,
  output bgd_pkg::btn_ev_t             ev_o
);

  logic                 pressed;
  logic [TIME_BITS-1:0] eff_start;
  logic                 eff_long_rep;
  logic [TIME_BITS-1:0] held_time;

  assign pressed = ~level_i;

  // a fresh press restarts the timer and clears the long flag
  assign eff_start    = flags_i.held ? start_i : now_i;
  assign eff_long_rep = flags_i.held & flags_i.long_rep;
  assign held_time    = now_i - eff_start;

  always_comb begin
    flags_o = flags_i;
    start_o = start_i;
    ev_o    = '0;
    if (pressed) begin
      ev_o.long_ev     = ~eff_long_rep &&
                         (held_time >= TIME_BITS'(long_press_us_i));
      flags_o.held     = 1'b1;
      flags_o.long_rep = eff_long_rep | ev_o.long_ev;
      start_o          = eff_start;
    end else begin
      flags_o.held  = 1'b0;
      ev_o.click_ev = flags_i.held & ~flags_i.long_rep;
    end
  end

endmodule

// ----- hw/rtl/bgd_window.sv -----
// double-click window for the centre button
module bgd_window #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic [TIME_BITS-1:0]      now_i,
  input  bgd_pkg::btn_ev_t          center_ev_i,
  input  logic                      awaiting_i,
  input  logic [TIME_BITS-1:0]      first_click_i,
  input  logic [bgd_pkg::CFG_W-1:0] double_click_us_i,
  output logic                      awaiting_o,
  output logic [TIME_BITS-1:0]      first_click_o,
  output bgd_pkg::event_e           code_o
);

  logic [TIME_BITS-1:0] since_click;
  logic                 in_window;

  assign since_click = now_i - first_click_i;
  assign in_window   = since_click <= TIME_BITS'(double_click_us_i);

  always_comb begin
    awaiting_o    = awaiting_i;
    first_click_o = first_click_i;
    code_o        = bgd_pkg::EV_NONE;
    if (center_ev_i.long_ev) begin
      awaiting_o = 1'b0;
      code_o     = bgd_pkg::EV_CENTER_LONG;
    end else if (center_ev_i.click_ev) begin
      if (!awaiting_i) begin
        awaiting_o    = 1'b1;
        first_click_o = now_i;
      end else if (in_window) begin
        awaiting_o = 1'b0;
        code_o     = bgd_pkg::EV_CENTER_DOUBLE;
      end else begin
        // late second click restarts the window
        first_click_o = now_i;
      end
    end else if (awaiting_i && !in_window) begin
      awaiting_o = 1'b0;
      code_o     = bgd_pkg::EV_CENTER;
    end
  end

endmodule

// ----- hw/rtl/button_gesture_detector.sv -----
// top level of the button gesture detector: poll register, decision logic, event register
//
// usage
//   input channel (in_valid_i / in_ready_o) takes one poll word: a microsecond
//   timestamp and the active-low levels of centre, up, down, left and right.
//   output channel (out_valid_o / out_ready_i) gives one event code per poll,
//   in poll order, 0 when nothing happened.
//   config port: cfg_we_i writes cfg_wdata_i to register cfg_addr_i at once
//   (0 long-press time, 1 double-click window); write only while idle.
// flow
//   an accepted poll is held in the poll register and its event is then loaded
//   into the event register; one poll per cycle is sustained while the receiver
//   takes each event. The evaluation of all five buttons, the timer compares and
//   the priority pick are combinational, between the poll and event registers.
// stalls
//   while the event register is full and the receiver holds off, one more
//   poll is taken into the poll register and then in_ready_o drops; nothing
//   is lost or repeated.
// reset
//   rst_ni clears all button state, the window, both stages and loads the
//   default long-press (800 ms) and double-click (400 ms) times.
module button_gesture_detector #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // poll channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [47:0] now_us_i,
  input  logic        center_level_i,
  input  logic        up_level_i,
  input  logic        down_level_i,
  input  logic        left_level_i,
  input  logic        right_level_i,
  // event channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  event_code_o,
  // configuration
  input  logic                      cfg_we_i,
  input  logic                      cfg_addr_i,
  input  logic [bgd_pkg::CFG_W-1:0] cfg_wdata_i
);

  localparam int unsigned NB = bgd_pkg::NUM_BUTTONS;

  // configuration registers
  logic [bgd_pkg::CFG_W-1:0] long_press_q;
  logic [bgd_pkg::CFG_W-1:0] double_click_q;

  // poll register
  logic                 in_valid_q;
  logic [TIME_BITS-1:0] now_q;
  logic [NB-1:0]        levels_q;

  // event register
  logic             out_valid_q;
  bgd_pkg::event_e  event_q;

  // gesture state
  bgd_pkg::btn_flags_t  flags_q [NB];
  logic [TIME_BITS-1:0] start_q [NB];
  logic                 awaiting_q;
  logic [TIME_BITS-1:0] first_click_q;

  // per-button proposals
  bgd_pkg::btn_flags_t  flags_d [NB];
  logic [TIME_BITS-1:0] start_d [NB];
  bgd_pkg::btn_ev_t     btn_ev  [NB];
  logic                 awaiting_d;
  logic [TIME_BITS-1:0] first_click_d;
  bgd_pkg::event_e      center_code;

  logic            advance;
  logic            in_fire;
  logic [NB-1:0]   reach;
  logic [NB-1:0]   hit;
  bgd_pkg::event_e event_d;

  // the poll moves on when the event register is free or being emptied
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  assign out_valid_o  = out_valid_q;
  assign event_code_o = event_q;

  for (genvar g = 0; g < NB; g++) begin : g_btn
    bgd_button #(
      .TIME_BITS(TIME_BITS)
    ) u_button (
      .level_i        (levels_q[g]),
      .now_i          (now_q),
      .flags_i        (flags_q[g]),
      .start_i        (start_q[g]),
      .long_press_us_i(long_press_q),
      .flags_o        (flags_d[g]),
      .start_o        (start_d[g]),
      .ev_o           (btn_ev[g])
    );
  end

  bgd_window #(
    .TIME_BITS(TIME_BITS)
  ) u_window (
    .now_i            (now_q),
    .center_ev_i      (btn_ev[bgd_pkg::BTN_CENTER]),
    .awaiting_i       (awaiting_q),
    .first_click_i    (first_click_q),
    .double_click_us_i(double_click_q),
    .awaiting_o       (awaiting_d),
    .first_click_o    (first_click_d),
    .code_o           (center_code)
  );

  // fixed priority: the first button with an event ends the poll, later
  // buttons keep their state untouched
  always_comb begin
    reach   = '0;
    hit     = '0;
    event_d = center_code;
    reach[0] = 1'b1;
    hit[0]   = center_code != bgd_pkg::EV_NONE;
    for (int i = 1; i < NB; i++) begin
      reach[i] = reach[i-1] & ~hit[i-1];
      hit[i]   = reach[i] & (btn_ev[i].long_ev | btn_ev[i].click_ev);
      if (hit[i]) begin
        event_d = bgd_pkg::btn_code(bgd_pkg::BTN_IDX_W'(i), btn_ev[i].long_ev);
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q   <= bgd_pkg::LONG_PRESS_RESET;
      double_click_q <= bgd_pkg::DOUBLE_CLICK_RESET;
    end else if (cfg_we_i) begin
      unique case (bgd_pkg::cfg_reg_e'(cfg_addr_i))
        bgd_pkg::CFG_LONG_PRESS:   long_press_q   <= cfg_wdata_i;
        bgd_pkg::CFG_DOUBLE_CLICK: double_click_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // poll register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      now_q    <= TIME_BITS'(now_us_i);
      levels_q <= {right_level_i, left_level_i, down_level_i, up_level_i, center_level_i};
    end
  end

  // event register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      event_q <= event_d;
    end
  end

  // gesture state, committed as the poll moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NB; i++) begin
        flags_q[i] <= '0;
        start_q[i] <= '0;
      end
      awaiting_q    <= 1'b0;
      first_click_q <= '0;
    end else if (advance) begin
      for (int i = 0; i < NB; i++) begin
        if (reach[i]) begin
          flags_q[i] <= flags_d[i];
          start_q[i] <= start_d[i];
        end
      end
      awaiting_q    <= awaiting_d;
      first_click_q <= first_click_d;
    end
  end

  // at most one button reports per poll
  a_single_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> $onehot0(hit))
    else $error("more than one button reported in one poll");

  // any centre event leaves no click pending
  a_center_clears_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (event_d == bgd_pkg::EV_CENTER || event_d == bgd_pkg::EV_CENTER_DOUBLE ||
                event_d == bgd_pkg::EV_CENTER_LONG) |=> !awaiting_q)
    else $error("centre event left the double-click window open");

  // state only moves with a poll
  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(awaiting_q) && $stable(first_click_q))
    else $error("window state changed without a poll");

  // a held poll is not dropped while the receiver stalls
  a_poll_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !out_ready_i |=> in_valid_q && $stable(now_q))
    else $error("pending poll lost during output stall");

  // a button after the reporting one is left as it was
  a_skip_later: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !reach[NB-1] |=> $stable(flags_q[NB-1]))
    else $error("unevaluated button state changed");

endmodule
